>>> rtl/lfcd_pkg.sv
// Shared package for the length-framed CRC-16 deframer.
// Holds phase and result codes, register defaults, the result type and the CRC byte update.
// No dependencies.
package lfcd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 16;
	localparam int unsigned CRC_W  = 16;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned PH_W   = 3;
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 16;

	// frame phases
	localparam logic [PH_W-1:0] PH_SOF     = 3'd0;
	localparam logic [PH_W-1:0] PH_LEN_LO  = 3'd1;
	localparam logic [PH_W-1:0] PH_LEN_HI  = 3'd2;
	localparam logic [PH_W-1:0] PH_PAYLOAD = 3'd3;
	localparam logic [PH_W-1:0] PH_CRC_LO  = 3'd4;
	localparam logic [PH_W-1:0] PH_CRC_HI  = 3'd5;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
	localparam logic [KIND_W-1:0] KIND_GOOD = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BAD  = 2'd2;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_START_BYTE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH = 1'd1;

	localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'hA5;
	localparam logic [LEN_W-1:0]  MAX_LENGTH_RST = 16'd1024;

	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] data_byte;
		logic              is_type_byte;
		logic [LEN_W-1:0]  body_length;
	} result_t;

	// CRC-16/CCITT-FALSE, one byte, MSB first
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> rtl/lfcd_in_reg.sv
// Input register of the deframer: holds one received byte until the core takes it.
// Uses lfcd_pkg for widths.
module lfcd_in_reg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [lfcd_pkg::BYTE_W-1:0]  rx_byte,
	input  logic                         take,
	output logic                         valid_s1,
	output logic [lfcd_pkg::BYTE_W-1:0]  byte_s1
);

	// hold while the stored byte is not taken
	assign in_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

>>> rtl/lfcd_core.sv
// Frame state machine, running CRC and configuration registers of the deframer.
// Uses lfcd_pkg for codes, the result type and the CRC update.
module lfcd_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [lfcd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lfcd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            take,
	input  logic [lfcd_pkg::BYTE_W-1:0]     byte_s1,
	output logic                            res_valid,
	output lfcd_pkg::result_t               res
);

	logic [lfcd_pkg::BYTE_W-1:0] start_byte_q;
	logic [lfcd_pkg::LEN_W-1:0]  max_length_q;
	logic [lfcd_pkg::PH_W-1:0]   phase_q, phase_d;
	logic [lfcd_pkg::LEN_W-1:0]  frame_length_q, frame_length_d;
	logic [lfcd_pkg::LEN_W-1:0]  bytes_seen_q, bytes_seen_d;
	logic [lfcd_pkg::CRC_W-1:0]  crc_q, crc_d;
	logic [lfcd_pkg::BYTE_W-1:0] crc_low_q, crc_low_d;
	logic [lfcd_pkg::LEN_W-1:0]  full_len;
	logic [lfcd_pkg::LEN_W-1:0]  seen_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= lfcd_pkg::START_BYTE_RST;
			max_length_q <= lfcd_pkg::MAX_LENGTH_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				lfcd_pkg::REG_START_BYTE: start_byte_q <= cfg_data[lfcd_pkg::BYTE_W-1:0];
				lfcd_pkg::REG_MAX_LENGTH: max_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign full_len = {byte_s1, frame_length_q[lfcd_pkg::BYTE_W-1:0]};
	assign seen_inc = bytes_seen_q + 16'd1;

	always_comb begin
		phase_d        = phase_q;
		frame_length_d = frame_length_q;
		bytes_seen_d   = bytes_seen_q;
		crc_d          = crc_q;
		crc_low_d      = crc_low_q;
		res_valid      = 1'b0;
		res            = '0;
		case (phase_q)
			lfcd_pkg::PH_LEN_LO: begin
				frame_length_d = {8'h00, byte_s1};
				phase_d        = lfcd_pkg::PH_LEN_HI;
			end
			lfcd_pkg::PH_LEN_HI: begin
				if (full_len == '0 || full_len > max_length_q) begin
					phase_d        = lfcd_pkg::PH_SOF;
					frame_length_d = '0;
					bytes_seen_d   = '0;
					crc_d          = lfcd_pkg::CRC_INIT;
					crc_low_d      = '0;
				end else begin
					frame_length_d = full_len;
					bytes_seen_d   = '0;
					crc_d          = lfcd_pkg::CRC_INIT;
					phase_d        = lfcd_pkg::PH_PAYLOAD;
				end
			end
			lfcd_pkg::PH_PAYLOAD: begin
				res_valid          = 1'b1;
				res.kind           = lfcd_pkg::KIND_DATA;
				res.data_byte      = byte_s1;
				res.is_type_byte   = (bytes_seen_q == '0);
				crc_d              = lfcd_pkg::crc_byte(crc_q, byte_s1);
				bytes_seen_d       = seen_inc;
				if (seen_inc >= frame_length_q) begin
					phase_d = lfcd_pkg::PH_CRC_LO;
				end
			end
			lfcd_pkg::PH_CRC_LO: begin
				crc_low_d = byte_s1;
				phase_d   = lfcd_pkg::PH_CRC_HI;
			end
			lfcd_pkg::PH_CRC_HI: begin
				res_valid = 1'b1;
				if ({byte_s1, crc_low_q} == crc_q) begin
					res.kind        = lfcd_pkg::KIND_GOOD;
					res.body_length = frame_length_q - 16'd1;
				end else begin
					res.kind = lfcd_pkg::KIND_BAD;
				end
				phase_d        = lfcd_pkg::PH_SOF;
				frame_length_d = '0;
				bytes_seen_d   = '0;
				crc_d          = lfcd_pkg::CRC_INIT;
				crc_low_d      = '0;
			end
			default: begin
				// hunting; unused codes fall back to the hunt
				phase_d        = lfcd_pkg::PH_SOF;
				frame_length_d = '0;
				bytes_seen_d   = '0;
				crc_d          = lfcd_pkg::CRC_INIT;
				crc_low_d      = '0;
				if (byte_s1 == start_byte_q) begin
					phase_d = lfcd_pkg::PH_LEN_LO;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= lfcd_pkg::PH_SOF;
			frame_length_q <= '0;
			bytes_seen_q   <= '0;
			crc_q          <= lfcd_pkg::CRC_INIT;
			crc_low_q      <= '0;
		end else if (take) begin
			phase_q        <= phase_d;
			frame_length_q <= frame_length_d;
			bytes_seen_q   <= bytes_seen_d;
			crc_q          <= crc_d;
			crc_low_q      <= crc_low_d;
		end
	end

endmodule

>>> rtl/lfcd_out_reg.sv
// Result register of the deframer: holds one result until the receiver takes it.
// Uses lfcd_pkg for the result type.
module lfcd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic              res_valid,
	input  lfcd_pkg::result_t res,
	input  logic              out_stall,
	output logic              out_free,
	output logic              out_valid,
	output lfcd_pkg::result_t res_q
);

	logic out_valid_q;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= load && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && load && res_valid) begin
			res_q <= res;
		end
	end

endmodule

>>> rtl/length_framed_crc16_deframer_unit.sv
// Top level of the length-framed CRC-16 deframer.
// Depends on lfcd_pkg, lfcd_in_reg, lfcd_core and lfcd_out_reg.
//
// Usage:
//   Input channel (in_valid / in_stall / rx_byte) carries one received byte per
//   request. The block hunts for start_byte, reads a 16-bit length low byte
//   first, forwards each payload byte (first one flagged as the type tag),
//   then checks the two trailing CRC-16/CCITT-FALSE bytes, low byte first.
//   Output channel (out_valid / out_stall) carries one result per payload byte
//   and one verdict per frame: good with body_length, or CRC error.
//   Bad lengths (zero or above max_length) drop back to the hunt silently.
//   A byte is registered at acceptance and processed by the core from the
//   input register; its result is registered when the core takes it.
//   Throughput: one byte per cycle while out_stall holds no pending result;
//   the byte-wide CRC update is combinational XOR logic between both registers.
//   Reset clears both registers' valid flags, returns to the hunt and loads
//   start_byte = 0xA5, max_length = 1024.
//   While out_stall holds a pending result, every byte waits in the input
//   register, whether it gives a result or not, and in_stall rises once that
//   register is full, until the output register frees up.
//   Config writes (cfg_write, cfg_index, cfg_data) take effect the next cycle.
module length_framed_crc16_deframer_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [lfcd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lfcd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [lfcd_pkg::BYTE_W-1:0]      rx_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [lfcd_pkg::KIND_W-1:0]      kind,
	output logic [lfcd_pkg::BYTE_W-1:0]      data_byte,
	output logic                             is_type_byte,
	output logic [lfcd_pkg::LEN_W-1:0]       body_length
);

	logic                        valid_s1;
	logic [lfcd_pkg::BYTE_W-1:0] byte_s1;
	logic                        take;
	logic                        out_free;
	logic                        res_valid;
	lfcd_pkg::result_t           res;
	lfcd_pkg::result_t           res_q;

	assign take = valid_s1 && out_free;

	lfcd_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	lfcd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	lfcd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.res_valid (res_valid),
		.res       (res),
		.out_stall (out_stall),
		.out_free  (out_free),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign kind         = res_q.kind;
	assign data_byte    = res_q.data_byte;
	assign is_type_byte = res_q.is_type_byte;
	assign body_length  = res_q.body_length;

endmodule
